// ----- rtl/cisd_pkg.sv -----
package cisd_pkg;

    localparam int unsigned VALUE_W = 30;
    localparam int unsigned LEN_W   = 7;

    // Smallest values that need the two-byte and the four-byte forms.
    localparam logic [VALUE_W-1:0] MIN_TWO_BYTE  = VALUE_W'(64);
    localparam logic [VALUE_W-1:0] MIN_FOUR_BYTE = VALUE_W'(16384);

    // Bytes beyond the first byte's count field in the big form.
    localparam logic [LEN_W-1:0] BIG_EXTRA = LEN_W'(5);

    typedef enum logic [1:0] {
        FORM_ONE  = 2'd0,
        FORM_TWO  = 2'd1,
        FORM_FOUR = 2'd2,
        FORM_BIG  = 2'd3
    } t_form;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONCANON = 2'd1,
        ST_EARLY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] decoded_value;
        logic [LEN_W-1:0]   encoded_length;
        logic [1:0]         form_kind;
        logic [1:0]         status;
    } t_out;

endpackage

// ----- rtl/compact_int_stream_decoder.sv -----
// The result for the beat that completes an integer, or for the beat flagged as
// the buffer end, is valid in the cycle after that beat.
// Throughput: one input beat per cycle; the decode state is a single
// shift-and-add accumulator. A new beat is taken whenever the output register
// is empty or being read in the same cycle.
// Synchronous active-low reset returns the decoder to idle.
module compact_int_stream_decoder
    import cisd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic               r_in_progress;
    logic [LEN_W-1:0]   r_bytes_seen;
    logic [LEN_W-1:0]   r_bytes_expected;
    t_form              r_form_seen;
    logic [VALUE_W-1:0] r_value_acc;
    logic               r_out_valid;
    t_out               r_out_data;

    logic               n_in_progress;
    logic [LEN_W-1:0]   n_bytes_seen;
    logic [LEN_W-1:0]   n_bytes_expected;
    t_form              n_form_seen;
    logic [VALUE_W-1:0] n_value_acc;

    logic               accept;
    logic               emit;
    t_out               result;
    logic [4:0]         shift_amt;
    logic [VALUE_W-1:0] final_value;
    t_status            final_status;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_in_progress    = r_in_progress;
        n_bytes_seen     = r_bytes_seen;
        n_bytes_expected = r_bytes_expected;
        n_form_seen      = r_form_seen;
        n_value_acc      = r_value_acc;
        shift_amt        = 5'd0;

        if (!r_in_progress) begin
            n_form_seen   = t_form'(i_in_data.data_byte[1:0]);
            n_bytes_seen  = LEN_W'(1);
            n_in_progress = 1'b1;
            case (n_form_seen)
                FORM_ONE:  n_bytes_expected = LEN_W'(1);
                FORM_TWO:  n_bytes_expected = LEN_W'(2);
                FORM_FOUR: n_bytes_expected = LEN_W'(4);
                default:   n_bytes_expected = LEN_W'(i_in_data.data_byte[7:2]) + BIG_EXTRA;
            endcase
            n_value_acc = (n_form_seen == FORM_BIG) ? '0
                                                    : VALUE_W'(i_in_data.data_byte[7:2]);
        end else begin
            // Continuation byte k lands at bit 6 + 8*(k-1).
            case (r_bytes_seen[1:0])
                2'd1:    shift_amt = 5'd6;
                2'd2:    shift_amt = 5'd14;
                2'd3:    shift_amt = 5'd22;
                default: shift_amt = 5'd0;
            endcase
            if (r_form_seen == FORM_TWO || r_form_seen == FORM_FOUR) begin
                n_value_acc = r_value_acc + (VALUE_W'(i_in_data.data_byte) << shift_amt);
            end
            n_bytes_seen = r_bytes_seen + LEN_W'(1);
        end

        final_status = ST_OK;
        if (n_form_seen == FORM_TWO && n_value_acc < MIN_TWO_BYTE) begin
            final_status = ST_NONCANON;
        end else if (n_form_seen == FORM_FOUR && n_value_acc < MIN_FOUR_BYTE) begin
            final_status = ST_NONCANON;
        end
        final_value = (final_status != ST_OK || n_form_seen == FORM_BIG) ? '0 : n_value_acc;

        result.encoded_length = n_bytes_seen;
        result.form_kind      = n_form_seen;
        if (n_bytes_seen >= n_bytes_expected) begin
            emit                 = 1'b1;
            result.decoded_value = final_value;
            result.status        = final_status;
        end else if (i_in_data.buffer_end) begin
            emit                 = 1'b1;
            result.decoded_value = '0;
            result.status        = ST_EARLY;
        end else begin
            emit                 = 1'b0;
            result.decoded_value = '0;
            result.status        = ST_OK;
        end

        // Any result ends the integer, so the next beat starts a new one.
        if (emit) begin
            n_in_progress    = 1'b0;
            n_bytes_seen     = '0;
            n_bytes_expected = '0;
            n_form_seen      = FORM_ONE;
            n_value_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_progress    <= 1'b0;
            r_bytes_seen     <= '0;
            r_bytes_expected <= '0;
            r_form_seen      <= FORM_ONE;
            r_value_acc      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_in_progress    <= n_in_progress;
                r_bytes_seen     <= n_bytes_seen;
                r_bytes_expected <= n_bytes_expected;
                r_form_seen      <= n_form_seen;
                r_value_acc      <= n_value_acc;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_data <= result;
        end
    end

`ifndef ASSERT_OFF
    a_count_below_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_progress |-> (r_bytes_seen < r_bytes_expected))
        else $error("byte count reached the expected length without a result");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_progress |-> (r_bytes_seen == '0 && r_value_acc == '0))
        else $error("decode state not cleared while idle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK || o_out_data.form_kind == FORM_BIG))
        |-> (o_out_data.decoded_value == '0))
        else $error("nonzero value on a big-form or failed result");

    a_one_byte_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_in_progress && i_in_data.data_byte[1:0] == FORM_ONE)
        |=> (o_out_valid && o_out_data.form_kind == FORM_ONE
             && o_out_data.encoded_length == LEN_W'(1)))
        else $error("one-byte integer did not produce its result");
`endif

endmodule
